// ===== hdl/sts_pkg.sv =====
// Shared types and constants for the sun tracker servo controller.
// No dependencies; every other file in hdl/ imports this package.
package sts_pkg;

	// Sample and angle ranges.
	localparam int SAMPLE_BITS = 10;
	localparam int SAMPLE_MAX  = (1 << SAMPLE_BITS) - 1;
	localparam int ANGLE_MAX   = 180;
	localparam int ANGLE_BITS  = $clog2(ANGLE_MAX + 1);
	localparam int DIFF_BITS   = SAMPLE_BITS + 1;
	localparam int MAP_BITS    = SAMPLE_BITS + ANGLE_BITS;

	// Register widths.
	localparam int TOL_BITS   = 10;
	localparam int STEP_BITS  = 8;
	localparam int COUNT_BITS = 16;
	localparam int MOVE_BITS  = (ANGLE_BITS > STEP_BITS) ? ANGLE_BITS : STEP_BITS;

	// Configuration port.
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 16;
	localparam logic [CFG_INDEX_BITS-1:0] REG_TOL_LOW    = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_TOL_MID    = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_TOL_HIGH   = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_DEADBAND   = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_STEP       = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_COUNT_LOW  = 3'd5;
	localparam logic [CFG_INDEX_BITS-1:0] REG_COUNT_HIGH = 3'd6;

	// Mode requests and modes.
	localparam logic [1:0] REQ_NONE     = 2'd0;
	localparam logic [1:0] MODE_FIXED   = 2'd0;
	localparam logic [1:0] MODE_MANUAL  = 2'd1;
	localparam logic [1:0] MODE_TRACK   = 2'd2;

	// Indicator codes, from bright right to bright left.
	localparam logic [2:0] IND_POS_HIGH = 3'd0;
	localparam logic [2:0] IND_POS_MID  = 3'd1;
	localparam logic [2:0] IND_POS_LOW  = 3'd2;
	localparam logic [2:0] IND_CENTER   = 3'd3;
	localparam logic [2:0] IND_NEG_LOW  = 3'd4;
	localparam logic [2:0] IND_NEG_MID  = 3'd5;
	localparam logic [2:0] IND_NEG_HIGH = 3'd6;

	// Parked and reset angles, clamped to the travel.
	localparam logic [ANGLE_BITS-1:0] FIXED_ANGLE =
		ANGLE_BITS'((91 > ANGLE_MAX) ? ANGLE_MAX : 91);
	localparam logic [ANGLE_BITS-1:0] RESET_ANGLE =
		ANGLE_BITS'((90 > ANGLE_MAX) ? ANGLE_MAX : 90);

	// Division by ANGLE_MAX as a multiply by a rounded-up reciprocal. The
	// dividend is below 2^(ANGLE_BITS+COUNT_BITS), so the error stays well
	// under one step of the quotient and no correction is needed.
	localparam int PROD_BITS  = ANGLE_BITS + COUNT_BITS;
	localparam int DIV_SHIFT  = 32;
	localparam int RECIP_BITS = DIV_SHIFT - $clog2(ANGLE_MAX) + 1;
	localparam logic [RECIP_BITS-1:0] DIV_RECIP = RECIP_BITS'(
		((64'd1 << DIV_SHIFT) + 64'(ANGLE_MAX) - 64'd1) / 64'(ANGLE_MAX));

	typedef struct packed {
		logic [TOL_BITS-1:0]   tol_low;
		logic [TOL_BITS-1:0]   tol_mid;
		logic [TOL_BITS-1:0]   tol_high;
		logic [TOL_BITS-1:0]   deadband;
		logic [STEP_BITS-1:0]  step;
		logic [COUNT_BITS-1:0] count_low;
		logic [COUNT_BITS-1:0] count_high;
	} cfg_t;

	// Outcome of one control pass, as held in the first pipeline stage.
	typedef struct packed {
		logic [ANGLE_BITS-1:0] angle;
		logic [1:0]            mode;
		logic [2:0]            code;
	} pass_t;

	// Load enables for the stages behind the first one.
	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
	} stage_en_t;

endpackage

// ===== hdl/sun_tracker_servo_controller.sv =====
// Top level of the sun tracker servo controller: stream ports, handshake
// control and the stage valid chain. Depends on sts_pkg, sts_cfg, sts_loop
// and sts_compare.
//
// Usage
// -----
// Each beat on the slave stream is one pass of the tracker's control loop:
// an optional mode request plus the pot and the two light sensor samples.
// For every accepted beat the master stream delivers exactly one beat with
// the servo compare count, the indicator code, the active mode and the
// servo angle after the pass.
// The loop state (mode, angle, previous difference and pot mapping) is
// updated at the edge that accepts the beat, so the next beat may follow in
// the very next cycle. The result then moves through three more registers
// (product, reciprocal divide, offset add into the output register) before
// m_tvalid rises and the result beat is offered on the master stream. The
// block sustains one beat per cycle while m_tready stays high; the two
// multipliers in the compare path set the stage count.
// When the receiver stalls, the stages fill up behind the output register
// and s_tready drops once all four hold a result; no beat is lost.
// Reset (arst_n low, asynchronous) empties the pipeline and restores the
// register defaults, fixed mode, a pending mode entry and a 90 degree angle.
// Configuration is written through cfg_we/cfg_index/cfg_data while the block
// is idle; writes to indexes beyond the last register are ignored.
module sun_tracker_servo_controller (
	input  logic                               clk,
	input  logic                               arst_n,
	// Slave stream, tdata from bit 0: mode_request[1:0], pot_sample[11:2],
	// right_light[21:12], left_light[31:22].
	input  logic                               s_tvalid,
	output logic                               s_tready,
	input  logic [31:0]                        s_tdata,
	// Master stream, tdata from bit 0: servo_compare[15:0],
	// indicator_code[18:16], current_mode[20:19], servo_angle[28:21],
	// zeros in [31:29].
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [31:0]                        m_tdata,
	// Configuration write port.
	input  logic                               cfg_we,
	input  logic [sts_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [sts_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
	import sts_pkg::*;

	cfg_t                  cfg;
	pass_t                 pass_s1;
	pass_t                 pass_out;
	stage_en_t             en;
	logic [COUNT_BITS-1:0] servo_compare;

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic ready1, ready2, ready3, ready4;
	logic accept;

	// A stage can load when it is empty or its content moves on this cycle.
	assign ready4 = !valid_s4 || m_tready;
	assign ready3 = !valid_s3 || ready4;
	assign ready2 = !valid_s2 || ready3;
	assign ready1 = !valid_s1 || ready2;

	assign s_tready = ready1;
	assign accept   = s_tvalid && ready1;
	assign en.s2    = ready2 && valid_s1;
	assign en.s3    = ready3 && valid_s2;
	assign en.s4    = ready4 && valid_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (ready1) valid_s1 <= s_tvalid;
			if (ready2) valid_s2 <= valid_s1;
			if (ready3) valid_s3 <= valid_s2;
			if (ready4) valid_s4 <= valid_s3;
		end
	end

	sts_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	sts_loop u_loop (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.accept       (accept),
		.mode_request (s_tdata[1:0]),
		.pot_sample   (s_tdata[11:2]),
		.right_light  (s_tdata[21:12]),
		.left_light   (s_tdata[31:22]),
		.pass_s1      (pass_s1)
	);

	sts_compare u_compare (
		.clk           (clk),
		.cfg           (cfg),
		.en            (en),
		.pass_s1       (pass_s1),
		.servo_compare (servo_compare),
		.pass_out      (pass_out)
	);

	assign m_tvalid = valid_s4;
	assign m_tdata  = {3'b000, pass_out.angle, pass_out.mode, pass_out.code, servo_compare};

endmodule

// ===== hdl/sts_cfg.sv =====
// Configuration register file of the sun tracker servo controller.
// Depends on sts_pkg for the register indexes and the cfg_t struct.
module sts_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [sts_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [sts_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	output sts_pkg::cfg_t                      cfg
);
	import sts_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tol_low    <= TOL_BITS'(50);
			cfg_q.tol_mid    <= TOL_BITS'(150);
			cfg_q.tol_high   <= TOL_BITS'(300);
			cfg_q.deadband   <= TOL_BITS'(100);
			cfg_q.step       <= STEP_BITS'(1);
			cfg_q.count_low  <= COUNT_BITS'(33);
			cfg_q.count_high <= COUNT_BITS'(66);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TOL_LOW:    cfg_q.tol_low    <= cfg_data[TOL_BITS-1:0];
				REG_TOL_MID:    cfg_q.tol_mid    <= cfg_data[TOL_BITS-1:0];
				REG_TOL_HIGH:   cfg_q.tol_high   <= cfg_data[TOL_BITS-1:0];
				REG_DEADBAND:   cfg_q.deadband   <= cfg_data[TOL_BITS-1:0];
				REG_STEP:       cfg_q.step       <= cfg_data[STEP_BITS-1:0];
				REG_COUNT_LOW:  cfg_q.count_low  <= cfg_data[COUNT_BITS-1:0];
				REG_COUNT_HIGH: cfg_q.count_high <= cfg_data[COUNT_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hdl/sts_loop.sv =====
// Control-loop state of the sun tracker: mode, angle and the values kept
// from the previous pass, plus the indicator code. Depends on sts_pkg.
module sts_loop (
	input  logic                            clk,
	input  logic                            arst_n,
	input  sts_pkg::cfg_t                   cfg,
	input  logic                            accept,
	input  logic [1:0]                      mode_request,
	input  logic [sts_pkg::SAMPLE_BITS-1:0] pot_sample,
	input  logic [sts_pkg::SAMPLE_BITS-1:0] right_light,
	input  logic [sts_pkg::SAMPLE_BITS-1:0] left_light,
	output sts_pkg::pass_t                  pass_s1
);
	import sts_pkg::*;

	logic [1:0]                  mode_q;
	logic                        just_switched_q;
	logic [ANGLE_BITS-1:0]       angle_q;
	logic signed [DIFF_BITS-1:0] prev_diff_q;
	logic [ANGLE_BITS-1:0]       prev_manual_q;

	logic [1:0]                  mode_n;
	logic                        entry;
	logic [ANGLE_BITS-1:0]       angle_n;
	logic [ANGLE_BITS-1:0]       track_angle;
	logic [DIFF_BITS-1:0]        prev_mag;
	logic [MOVE_BITS:0]          angle_w;
	logic [MOVE_BITS:0]          step_w;
	logic [MOVE_BITS:0]          room_w;
	logic [MAP_BITS-1:0]         map_prod;
	logic [ANGLE_BITS-1:0]       map_hi;
	logic [SAMPLE_BITS:0]        map_sum;
	logic [ANGLE_BITS-1:0]       manual_angle;
	logic signed [DIFF_BITS-1:0] diff;
	logic [DIFF_BITS-1:0]        diff_neg;
	logic [SAMPLE_BITS-1:0]      diff_mag;
	logic                        diff_pos;
	logic [2:0]                  code;

	// Tracking move from the previous difference, saturating at both ends.
	always_comb begin
		prev_mag    = prev_diff_q[DIFF_BITS-1] ? DIFF_BITS'(-prev_diff_q)
		                                       : DIFF_BITS'(prev_diff_q);
		angle_w     = (MOVE_BITS+1)'(angle_q);
		step_w      = (MOVE_BITS+1)'(cfg.step);
		room_w      = (MOVE_BITS+1)'(ANGLE_MAX) - angle_w;
		track_angle = angle_q;
		if (prev_mag > DIFF_BITS'(cfg.deadband)) begin
			if (!prev_diff_q[DIFF_BITS-1]) begin
				track_angle = (step_w >= room_w) ? ANGLE_BITS'(ANGLE_MAX)
				                                 : ANGLE_BITS'(angle_w + step_w);
			end else begin
				track_angle = (step_w >= angle_w) ? '0 : ANGLE_BITS'(angle_w - step_w);
			end
		end
	end

	// Pot mapping pot*ANGLE_MAX/SAMPLE_MAX. Writing the product as
	// hi*2^N + lo gives hi*(2^N-1) + (hi+lo), and hi+lo stays below twice
	// the divisor, so one compare finishes the quotient.
	always_comb begin
		map_prod     = MAP_BITS'(pot_sample) * MAP_BITS'(ANGLE_MAX);
		map_hi       = map_prod[MAP_BITS-1:SAMPLE_BITS];
		map_sum      = (SAMPLE_BITS+1)'(map_hi) + (SAMPLE_BITS+1)'(map_prod[SAMPLE_BITS-1:0]);
		manual_angle = map_hi + ANGLE_BITS'(map_sum >= (SAMPLE_BITS+1)'(SAMPLE_MAX));
	end

	// Mode request and angle update for this pass.
	always_comb begin
		mode_n  = (mode_request != REQ_NONE) ? mode_request - 2'd1 : mode_q;
		entry   = (mode_request != REQ_NONE) || just_switched_q;
		angle_n = angle_q;
		case (mode_n)
			MODE_FIXED:  if (entry) angle_n = FIXED_ANGLE;
			MODE_MANUAL: if (!entry) angle_n = prev_manual_q;
			default:     if (!entry) angle_n = track_angle;
		endcase
	end

	// Indicator code of the new light difference.
	always_comb begin
		diff     = DIFF_BITS'({1'b0, right_light}) - DIFF_BITS'({1'b0, left_light});
		diff_neg = DIFF_BITS'(-diff);
		diff_mag = diff[DIFF_BITS-1] ? diff_neg[SAMPLE_BITS-1:0] : diff[SAMPLE_BITS-1:0];
		diff_pos = !diff[DIFF_BITS-1] && (diff != '0);
		if (diff_mag < cfg.tol_low) begin
			code = IND_CENTER;
		end else if (diff_mag < cfg.tol_mid) begin
			code = diff_pos ? IND_POS_LOW : IND_NEG_LOW;
		end else if (diff_mag < cfg.tol_high) begin
			code = diff_pos ? IND_POS_MID : IND_NEG_MID;
		end else begin
			code = diff_pos ? IND_POS_HIGH : IND_NEG_HIGH;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q          <= MODE_FIXED;
			just_switched_q <= 1'b1;
			angle_q         <= RESET_ANGLE;
			prev_diff_q     <= '0;
			prev_manual_q   <= '0;
		end else if (accept) begin
			mode_q          <= mode_n;
			just_switched_q <= 1'b0;
			angle_q         <= angle_n;
			prev_diff_q     <= diff;
			prev_manual_q   <= manual_angle;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pass_s1.angle <= angle_n;
			pass_s1.mode  <= mode_n;
			pass_s1.code  <= code;
		end
	end

endmodule

// ===== hdl/sts_compare.sv =====
// Servo compare count pipeline: angle*(high-low)/ANGLE_MAX + low with
// truncation toward zero, over three stages. Depends on sts_pkg.
module sts_compare (
	input  logic                           clk,
	input  sts_pkg::cfg_t                  cfg,
	input  sts_pkg::stage_en_t             en,
	input  sts_pkg::pass_t                 pass_s1,
	output logic [sts_pkg::COUNT_BITS-1:0] servo_compare,
	output sts_pkg::pass_t                 pass_out
);
	import sts_pkg::*;

	localparam int FULL_BITS = PROD_BITS + RECIP_BITS;

	logic signed [COUNT_BITS:0]  span;
	logic [COUNT_BITS:0]         span_neg;
	logic [COUNT_BITS-1:0]       span_mag;
	logic [FULL_BITS-1:0]        quot_full;

	logic [PROD_BITS-1:0]        prod_s2;
	logic                        neg_s2;
	logic [COUNT_BITS-1:0]       low_s2;
	pass_t                       pass_s2;

	logic [COUNT_BITS-1:0]       quot_s3;
	logic                        neg_s3;
	logic [COUNT_BITS-1:0]       low_s3;
	pass_t                       pass_s3;

	logic [COUNT_BITS-1:0]       compare_s4;
	pass_t                       pass_s4;

	always_comb begin
		span     = (COUNT_BITS+1)'({1'b0, cfg.count_high}) - (COUNT_BITS+1)'({1'b0, cfg.count_low});
		span_neg = (COUNT_BITS+1)'(-span);
		span_mag = span[COUNT_BITS] ? span_neg[COUNT_BITS-1:0] : span[COUNT_BITS-1:0];
		quot_full = FULL_BITS'(prod_s2) * FULL_BITS'(DIV_RECIP);
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			prod_s2 <= PROD_BITS'(pass_s1.angle) * PROD_BITS'(span_mag);
			neg_s2  <= span[COUNT_BITS];
			low_s2  <= cfg.count_low;
			pass_s2 <= pass_s1;
		end
		if (en.s3) begin
			quot_s3 <= quot_full[DIV_SHIFT+COUNT_BITS-1:DIV_SHIFT];
			neg_s3  <= neg_s2;
			low_s3  <= low_s2;
			pass_s3 <= pass_s2;
		end
		if (en.s4) begin
			compare_s4 <= neg_s3 ? low_s3 - quot_s3 : low_s3 + quot_s3;
			pass_s4    <= pass_s3;
		end
	end

	assign servo_compare = compare_s4;
	assign pass_out      = pass_s4;

endmodule

// ===== tb/sts_pass_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the sun tracker servo controller: watches the stream and config ports,
// predicts each result beat from its own copy of the control loop and compares. Uses sts_pkg.
module sts_pass_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	input  logic                               s_tready,
	input  logic [31:0]                        s_tdata,
	input  logic                               m_tvalid,
	input  logic                               m_tready,
	input  logic [31:0]                        m_tdata,
	input  logic                               cfg_we,
	input  logic [sts_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [sts_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	output int                                 mismatches = 0,
	output int                                 outstanding = 0
);
	import sts_pkg::*;

	localparam int PARK_ANGLE = (91 > ANGLE_MAX) ? ANGLE_MAX : 91;
	localparam int HOME_ANGLE = (90 > ANGLE_MAX) ? ANGLE_MAX : 90;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] left;
		logic [SAMPLE_BITS-1:0] right;
		logic [SAMPLE_BITS-1:0] pot;
		logic [1:0]             req;
	} pass_in_t;

	typedef struct packed {
		logic [2:0]            spare;
		logic [ANGLE_BITS-1:0] angle;
		logic [1:0]            mode;
		logic [2:0]            code;
		logic [COUNT_BITS-1:0] compare;
	} pass_out_t;

	// Register copies, updated from the write port.
	logic [TOL_BITS-1:0]   tol_low, tol_mid, tol_high, deadband;
	logic [STEP_BITS-1:0]  step;
	logic [COUNT_BITS-1:0] count_low, count_high;

	// Loop state.
	logic [1:0]                   mode_now;
	logic                         entry_due;
	logic [ANGLE_BITS-1:0]        angle_now;
	logic signed [DIFF_BITS-1:0]  prev_diff;
	logic [SAMPLE_BITS-1:0]       prev_pot;

	pass_out_t awaited_results[$];
	int        errors = 0;

	function automatic logic [2:0] band_code(input int diff);
		int mag;
		mag = (diff < 0) ? -diff : diff;
		if (mag < int'(tol_low))
			return IND_CENTER;
		if (diff > 0) begin
			if (mag < int'(tol_mid))
				return IND_POS_LOW;
			if (mag < int'(tol_high))
				return IND_POS_MID;
			return IND_POS_HIGH;
		end
		if (mag < int'(tol_mid))
			return IND_NEG_LOW;
		if (mag < int'(tol_high))
			return IND_NEG_MID;
		return IND_NEG_HIGH;
	endfunction

	task automatic predict_pass(input pass_in_t beat, output pass_out_t res);
		int     diff;
		int     mag;
		longint cmp;
		if (beat.req != REQ_NONE) begin
			mode_now = beat.req - 2'd1;
			entry_due = 1'b1;
		end
		if (entry_due) begin
			// The first pass in a mode only moves the servo in fixed mode.
			if (mode_now == MODE_FIXED)
				angle_now = ANGLE_BITS'(PARK_ANGLE);
			entry_due = 1'b0;
		end else if (mode_now == MODE_MANUAL) begin
			angle_now = ANGLE_BITS'(int'(prev_pot) * ANGLE_MAX / SAMPLE_MAX);
		end else if (mode_now == MODE_TRACK) begin
			mag = (prev_diff < 0) ? -int'(prev_diff) : int'(prev_diff);
			if (mag > int'(deadband)) begin
				if (prev_diff > 0)
					angle_now = (int'(step) >= ANGLE_MAX - int'(angle_now)) ?
						ANGLE_BITS'(ANGLE_MAX) : ANGLE_BITS'(int'(angle_now) + int'(step));
				else
					angle_now = (int'(step) >= int'(angle_now)) ?
						'0 : ANGLE_BITS'(int'(angle_now) - int'(step));
			end
		end
		diff = int'(beat.right) - int'(beat.left);
		prev_pot = beat.pot;
		prev_diff = DIFF_BITS'(diff);
		cmp = longint'(angle_now) * (longint'(count_high) - longint'(count_low)) / ANGLE_MAX
			+ longint'(count_low);
		res.spare = '0;
		res.angle = angle_now;
		res.mode = mode_now;
		res.code = band_code(diff);
		res.compare = COUNT_BITS'(cmp);
	endtask

	task automatic check_field(input string field, input longint want, input longint got);
		if (want != got) begin
			$display("%0t: %s expected %0d, got %0d", $time, field, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		pass_out_t want;
		pass_out_t seen;
		if (!arst_n) begin
			tol_low = 10'd50;
			tol_mid = 10'd150;
			tol_high = 10'd300;
			deadband = 10'd100;
			step = 8'd1;
			count_low = 16'd33;
			count_high = 16'd66;
			mode_now = MODE_FIXED;
			entry_due = 1'b1;
			angle_now = ANGLE_BITS'(HOME_ANGLE);
			prev_diff = '0;
			prev_pot = '0;
			awaited_results.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_TOL_LOW:    tol_low = cfg_data[TOL_BITS-1:0];
					REG_TOL_MID:    tol_mid = cfg_data[TOL_BITS-1:0];
					REG_TOL_HIGH:   tol_high = cfg_data[TOL_BITS-1:0];
					REG_DEADBAND:   deadband = cfg_data[TOL_BITS-1:0];
					REG_STEP:       step = cfg_data[STEP_BITS-1:0];
					REG_COUNT_LOW:  count_low = cfg_data[COUNT_BITS-1:0];
					REG_COUNT_HIGH: count_high = cfg_data[COUNT_BITS-1:0];
					default: ;
				endcase
			end
			// Results are checked before this edge's input beat is predicted, since a
			// beat can never produce its result at the edge that accepts it.
			if (m_tvalid && m_tready) begin
				seen = m_tdata;
				if (awaited_results.size() == 0) begin
					$display("%0t: result beat %h with no pass outstanding", $time, m_tdata);
					errors++;
				end else begin
					want = awaited_results.pop_front();
					check_field("servo_compare", want.compare, seen.compare);
					check_field("indicator_code", want.code, seen.code);
					check_field("current_mode", want.mode, seen.mode);
					check_field("servo_angle", want.angle, seen.angle);
					check_field("padding", want.spare, seen.spare);
				end
			end
			if (s_tvalid && s_tready) begin
				predict_pass(pass_in_t'(s_tdata), want);
				awaited_results.push_back(want);
			end
		end
		mismatches <= errors;
		outstanding <= awaited_results.size();
	end

endmodule

// ===== tb/tb_sun_tracker_servo_controller.sv =====
`timescale 1ns / 1ps
// Top of the sun tracker servo controller testbench: clock, reset, stimulus, flow control
// and the verdict. Depends on sts_pkg, the block's RTL and sts_pass_checker.
module tb_sun_tracker_servo_controller;
	import sts_pkg::*;

	// Mode requests as they travel in the low bits of a slave beat.
	localparam logic [1:0] REQ_FIXED  = 2'd1;
	localparam logic [1:0] REQ_MANUAL = 2'd2;
	localparam logic [1:0] REQ_TRACK  = 2'd3;
	// A register index past the last register; writes to it must change nothing.
	localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 3'd7;

	localparam int PHASE_BEATS  = 85;
	localparam int DRAIN_CYCLES = 8;
	// Longest gap plus longest stall is far below QUIET_LIMIT, so a quiet
	// spell this long means the block has hung.
	localparam int QUIET_LIMIT  = 2000;

	typedef enum {RX_OPEN, RX_COIN, RX_DUTY} rx_style_t;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      s_tvalid = 1'b0;
	logic                      s_tready;
	// tdata from bit 0: mode_request[1:0], pot_sample[11:2], right_light[21:12],
	// left_light[31:22].
	logic [31:0]               s_tdata = '0;
	logic                      m_tvalid;
	logic                      m_tready = 1'b0;
	// tdata from bit 0: servo_compare[15:0], indicator_code[18:16],
	// current_mode[20:19], servo_angle[28:21], zeros in [31:29].
	logic [31:0]               m_tdata;
	logic                      cfg_we = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

	int mismatches;
	int outstanding;

	// Slave beats waiting to be presented, and the sender's burst state.
	logic [31:0] feed_q[$];
	int          burst_left = 0;
	int          gap_left = 0;

	// What was last written to the three tolerances and the deadband, so that the
	// random light pairs can aim at the band edges currently in force.
	int band_edges[4] = '{50, 150, 300, 100};

	// Receiver stall pattern.
	rx_style_t rx_style = RX_OPEN;
	int        rx_left = 0;
	int        rx_on = 1;
	int        rx_off = 1;
	int        rx_tick = 0;

	int quiet_cycles = 0;

	initial begin
		forever #10 clk = ~clk;
	end

	sun_tracker_servo_controller i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	sts_pass_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	// Sender: beats go out in bursts of random length. After the last beat of a
	// burst has been taken, the line stays idle for a random gap, mostly short,
	// sometimes long, sometimes none at all so that bursts run together.
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!(s_tvalid && !s_tready)) begin
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				s_tvalid <= 1'b0;
			end else if (feed_q.size() != 0) begin
				s_tvalid <= 1'b1;
				s_tdata <= feed_q.pop_front();
				if (burst_left > 1) begin
					burst_left <= burst_left - 1;
				end else begin
					burst_left <= $urandom_range(1, 40);
					gap_left <= ($urandom_range(0, 3) == 0) ?
						$urandom_range(5, 30) : $urandom_range(0, 3);
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver: every so often it switches among always ready, a coin toss per
	// cycle, and a duty cycle of ready spells against stall spells of random length.
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_style = rx_style_t'($urandom_range(0, 2));
			rx_left = $urandom_range(32, 200);
			rx_on = $urandom_range(1, 8);
			rx_off = $urandom_range(1, 24);
			rx_tick = 0;
		end else begin
			rx_left = rx_left - 1;
		end
		rx_tick = (rx_tick + 1) % (rx_on + rx_off);
		case (rx_style)
			RX_OPEN: m_tready <= 1'b1;
			RX_COIN: m_tready <= ($urandom_range(0, 1) == 1);
			default: m_tready <= (rx_tick < rx_on);
		endcase
	end

	// Watchdog: any beat on either side restarts the count.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// A sample that hits either end of the range a quarter of the time.
	function automatic logic [SAMPLE_BITS-1:0] draw_sample();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return SAMPLE_BITS'(SAMPLE_MAX);
			default: return SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX));
		endcase
	endfunction

	// Places a light pair with the given magnitude of difference anywhere in range.
	task automatic place_pair(input int mag, input bit left_brighter,
		output logic [SAMPLE_BITS-1:0] right_s, output logic [SAMPLE_BITS-1:0] left_s);
		int base;
		base = $urandom_range(0, SAMPLE_MAX - mag);
		right_s = SAMPLE_BITS'(left_brighter ? base : base + mag);
		left_s = SAMPLE_BITS'(left_brighter ? base + mag : base);
	endtask

	// Light pairs. A nonzero lean gives a tracking run a steady direction half of
	// the time, with a difference past the deadband, so the angle can run into
	// either end stop. Otherwise the pair lands on a band edge, is level, or is
	// drawn freely.
	task automatic pick_lights(input int lean,
		output logic [SAMPLE_BITS-1:0] right_s, output logic [SAMPLE_BITS-1:0] left_s);
		int mag;
		int floor_mag;
		if (lean != 0 && $urandom_range(0, 1) == 1) begin
			floor_mag = (band_edges[3] < SAMPLE_MAX) ? band_edges[3] + 1 : SAMPLE_MAX;
			mag = $urandom_range(floor_mag, SAMPLE_MAX);
			place_pair(mag, lean < 0, right_s, left_s);
		end else begin
			case ($urandom_range(0, 3))
				0: begin
					mag = band_edges[$urandom_range(0, 3)] + int'($urandom_range(0, 2)) - 1;
					if (mag < 0)
						mag = 0;
					if (mag > SAMPLE_MAX)
						mag = SAMPLE_MAX;
					place_pair(mag, $urandom_range(0, 1) == 1, right_s, left_s);
				end
				1: begin
					right_s = draw_sample();
					left_s = right_s;
				end
				default: begin
					right_s = draw_sample();
					left_s = draw_sample();
				end
			endcase
		end
	endtask

	task automatic push_pass(input logic [1:0] req, input int pot,
		input int right_s, input int left_s);
		feed_q.push_back({SAMPLE_BITS'(left_s), SAMPLE_BITS'(right_s), SAMPLE_BITS'(pot), req});
	endtask

	// Random passes, mostly as runs that open with a mode request and then carry
	// plain passes, the way buttons get pressed. A run now and then is pure noise
	// with a random request on every pass, and a stray request can land mid-run.
	task automatic random_passes(input int count);
		int                     remaining;
		int                     run;
		int                     lean;
		bit                     noisy;
		logic [1:0]             req;
		logic [SAMPLE_BITS-1:0] right_s;
		logic [SAMPLE_BITS-1:0] left_s;
		remaining = count;
		while (remaining > 0) begin
			run = $urandom_range(2, 25);
			if (run > remaining)
				run = remaining;
			lean = int'($urandom_range(0, 2)) - 1;
			noisy = ($urandom_range(0, 9) == 0);
			for (int k = 0; k < run; k++) begin
				if (noisy || (k > 0 && $urandom_range(0, 29) == 0))
					req = 2'($urandom_range(0, 3));
				else if (k == 0)
					req = 2'($urandom_range(REQ_FIXED, REQ_TRACK));
				else
					req = REQ_NONE;
				pick_lights(lean, right_s, left_s);
				push_pass(req, int'(draw_sample()), int'(right_s), int'(left_s));
			end
			remaining -= run;
		end
	endtask

	// Returns once every queued beat has gone in and every result has come back
	// and a drain wait has passed, so that nothing is still moving through the stages.
	task automatic wait_idle();
		while (feed_q.size() != 0 || s_tvalid || outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// One register write; cfg_we is left high so back-to-back writes run together.
	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
		input logic [CFG_DATA_BITS-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	task automatic set_config(input int tl, input int tm, input int th, input int db,
		input int st, input int cl, input int ch);
		write_reg(REG_TOL_LOW, CFG_DATA_BITS'(tl));
		write_reg(REG_TOL_MID, CFG_DATA_BITS'(tm));
		write_reg(REG_TOL_HIGH, CFG_DATA_BITS'(th));
		write_reg(REG_DEADBAND, CFG_DATA_BITS'(db));
		write_reg(REG_STEP, CFG_DATA_BITS'(st));
		write_reg(REG_COUNT_LOW, CFG_DATA_BITS'(cl));
		write_reg(REG_COUNT_HIGH, CFG_DATA_BITS'(ch));
		band_edges[0] = tl % (1 << TOL_BITS);
		band_edges[1] = tm % (1 << TOL_BITS);
		band_edges[2] = th % (1 << TOL_BITS);
		band_edges[3] = db % (1 << TOL_BITS);
	endtask

	initial begin
		int tl;
		int tm;
		int th;
		int st;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed passes under the reset settings: tolerances 50/150/300,
		// deadband 100, one degree per step.
		push_pass(REQ_NONE, SAMPLE_MAX, 0, 0);            // pending fixed entry parks at 91
		push_pass(REQ_MANUAL, SAMPLE_MAX, 49, 0);         // manual entry holds the angle
		push_pass(REQ_NONE, 0, 50, 0);                    // full-scale pot maps to 180
		push_pass(REQ_NONE, 512, 149, 0);                 // zero pot maps to 0
		push_pass(REQ_MANUAL, 512, 150, 0);               // same mode asked again: entry pass
		push_pass(REQ_NONE, 1, 299, 0);                   // pot 512 maps to 90
		push_pass(REQ_NONE, 0, 300, 0);                   // pot 1 truncates to 0
		push_pass(REQ_TRACK, 0, SAMPLE_MAX, 0);           // tracking entry
		push_pass(REQ_NONE, 0, 0, SAMPLE_MAX);            // brighter right steps up
		push_pass(REQ_NONE, 0, 0, 49);                    // brighter left steps down
		push_pass(REQ_NONE, 0, 0, 50);                    // small difference, inside deadband
		push_pass(REQ_NONE, 0, 0, 100);
		push_pass(REQ_NONE, 0, 0, 101);                   // exactly the deadband: no move
		push_pass(REQ_NONE, 0, 150, 0);                   // one past it
		push_pass(REQ_NONE, 0, 0, 149);
		push_pass(REQ_NONE, 0, 0, 150);
		push_pass(REQ_NONE, 0, 0, 299);
		push_pass(REQ_NONE, 0, 0, 300);
		push_pass(REQ_NONE, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX);
		push_pass(REQ_TRACK, 0, 0, SAMPLE_MAX);           // same mode asked again in tracking
		push_pass(REQ_NONE, SAMPLE_MAX, 0, SAMPLE_MAX);
		push_pass(REQ_FIXED, 0, SAMPLE_MAX, 0);           // explicit fixed request parks
		push_pass(REQ_NONE, SAMPLE_MAX, 0, 0);            // fixed mode holds
		push_pass(REQ_FIXED, SAMPLE_MAX, 0, 0);           // fixed asked again parks again
		wait_idle();

		// Zero tolerances and deadband, the largest legal step and the full
		// compare span. A write to the unused index follows the register writes.
		set_config(0, 0, 0, 0, ANGLE_MAX, 0, 16'hFFFF);
		write_reg(REG_UNUSED, 16'hFFFF);
		cfg_we <= 1'b0;
		random_passes(PHASE_BEATS);
		wait_idle();

		// All ones on every tolerance, so the upper data bits must be dropped;
		// tracking can never move, the step is past the travel, and the compare
		// limits are reversed.
		set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, (1 << STEP_BITS) - 1, 16'hFFFF, 0);
		cfg_we <= 1'b0;
		random_passes(PHASE_BEATS);
		wait_idle();

		// Descending tolerances, a deadband of one, a zero step and equal
		// compare limits.
		set_config(300, 150, 50, 1, 0, 1000, 1000);
		cfg_we <= 1'b0;
		random_passes(PHASE_BEATS);
		wait_idle();

		// Random settings; the compare limits fall in either order.
		for (int phase = 0; phase < 5; phase++) begin
			tl = $urandom_range(0, 400);
			tm = tl + $urandom_range(0, 300);
			th = tm + $urandom_range(0, 323);
			case ($urandom_range(0, 7))
				0: st = 0;
				1: st = (1 << STEP_BITS) - 1;
				default: st = $urandom_range(1, ANGLE_MAX);
			endcase
			set_config(tl, tm, th, $urandom_range(0, 400), st,
				$urandom_range(0, 16'hFFFF), $urandom_range(0, 16'hFFFF));
			cfg_we <= 1'b0;
			random_passes(PHASE_BEATS);
			wait_idle();
		end

		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
